@@ hw/rtl/sha1md_pkg.sv @@
// Shared types and constants for the SHA-1 message digest block.
`timescale 1ns / 1ps

package sha1md_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_pad_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // working variables a..e of the compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] ROUND_SEED  = 7'd16;
    localparam logic [6:0] ROUND_Q1    = 7'd20;
    localparam logic [6:0] ROUND_Q2    = 7'd40;
    localparam logic [6:0] ROUND_Q3    = 7'd60;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [2:0] WORD_LAST   = 3'd4;
    localparam logic [63:0] BYTE_BITS  = 64'd8;

endpackage

@@ hw/rtl/sha1_message_digest_top.sv @@
// SHA-1 message digest: byte packing, padding sequencer, round loop and digest output.
// A message byte is taken while the block is idle; the byte that fills a block starts
// the 80 rounds on the shared round unit, then the chaining add.
// End of message: one pad byte per cycle (up to 72), one or two block compressions,
// then five digest items, one per cycle while not stalled.
// Sustained rate is set by the one-round-per-cycle loop; input stalls during compression.
// Synchronous active-low reset loads the initial chaining values and clears length.
`timescale 1ns / 1ps

module sha1_message_digest_top
    import sha1md_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state           r_state, n_state;
    t_pad_phase       r_phase, n_phase;
    logic [511:0]     r_blk, n_blk;
    logic [4:0][31:0] r_chain, n_chain;
    t_work            r_wk, n_wk;
    logic [6:0]       r_cnt, n_cnt;
    logic [5:0]       r_pos, n_pos;
    logic [63:0]      r_len, n_len;
    logic             r_padding, n_padding;
    logic             r_done, n_done;
    logic [2:0]       r_oidx, n_oidx;

    logic        in_acc;
    logic        out_acc;
    logic [7:0]  pad_byte;
    logic [5:0]  len_msb;
    logic [31:0] w_mix;
    logic [31:0] w_t;
    t_work       round_out;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // schedule word: block words come out of the top of the buffer first
    assign w_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign w_t   = (r_cnt < ROUND_SEED) ? r_blk[511:480] : {w_mix[30:0], w_mix[31]};

    assign len_msb = POS_LAST - {r_pos[2:0], 3'b000};

    always_comb begin
        case (r_phase)
            PH_MARK: pad_byte = PAD_MARK;
            PH_ZERO: pad_byte = 8'h00;
            PH_LEN:  pad_byte = r_len[len_msb -: 8];
            default: pad_byte = 8'h00;
        endcase
    end

    sha1md_round u_round (
        .i_work  (r_wk),
        .i_w     (w_t),
        .i_round (r_cnt),
        .o_work  (round_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.byte_present && r_pos == POS_LAST) begin
                        n_state = S_ROUND;
                    end else if (i_in_item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == POS_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_cnt == ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_done) begin
                    n_state = S_OUT;
                end else if (r_padding) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_acc && r_oidx == WORD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase   = r_phase;
        n_blk     = r_blk;
        n_chain   = r_chain;
        n_wk      = r_wk;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_len     = r_len;
        n_padding = r_padding;
        n_done    = r_done;
        n_oidx    = r_oidx;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.byte_present) begin
                        n_blk = {r_blk[503:0], i_in_item.data_byte};
                        n_pos = r_pos + 6'd1;
                        n_len = r_len + BYTE_BITS;
                    end
                    if (i_in_item.end_of_message) begin
                        n_padding = 1'b1;
                        n_phase   = PH_MARK;
                    end
                end
            end
            S_PAD: begin
                n_blk = {r_blk[503:0], pad_byte};
                n_pos = r_pos + 6'd1;
                if (r_phase != PH_LEN) begin
                    n_phase = (n_pos == LEN_POS) ? PH_LEN : PH_ZERO;
                end else if (r_pos == POS_LAST) begin
                    n_done = 1'b1;
                end
            end
            S_ROUND: begin
                n_wk  = round_out;
                n_blk = {r_blk[479:0], w_t};
                n_cnt = r_cnt + 7'd1;
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_wk.a;
                n_chain[1] = r_chain[1] + r_wk.b;
                n_chain[2] = r_chain[2] + r_wk.c;
                n_chain[3] = r_chain[3] + r_wk.d;
                n_chain[4] = r_chain[4] + r_wk.e;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == WORD_LAST) begin
                        n_chain   = H_INIT;
                        n_len     = '0;
                        n_pos     = '0;
                        n_padding = 1'b0;
                        n_done    = 1'b0;
                        n_oidx    = '0;
                    end
                end
            end
            default: ;
        endcase
        // load working variables when a block starts its rounds
        if (n_state == S_ROUND && r_state != S_ROUND) begin
            n_wk.a = r_chain[0];
            n_wk.b = r_chain[1];
            n_wk.c = r_chain[2];
            n_wk.d = r_chain[3];
            n_wk.e = r_chain[4];
            n_cnt  = '0;
        end
    end

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_out_valid            = (r_state == S_OUT);
    assign o_out_item.digest_word = r_chain[r_oidx];
    assign o_out_item.word_index  = r_oidx;
    assign o_out_item.last_word   = (r_oidx == WORD_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_MARK;
            r_chain   <= H_INIT;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_len     <= '0;
            r_padding <= 1'b0;
            r_done    <= 1'b0;
            r_oidx    <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_chain   <= n_chain;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_padding <= n_padding;
            r_done    <= n_done;
            r_oidx    <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_wk  <= n_wk;
    end

endmodule

@@ hw/rtl/sha1md_round.sv @@
// One SHA-1 round: round function, constant select and the new working word.
`timescale 1ns / 1ps

module sha1md_round
    import sha1md_pkg::*;
(
    input  t_work       i_work,
    input  logic [31:0] i_w,
    input  logic [6:0]  i_round,
    output t_work       o_work
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        if (i_round < ROUND_Q1) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = K_R0;
        end else if (i_round < ROUND_Q2) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_R1;
        end else if (i_round < ROUND_Q3) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = K_R2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_R3;
        end
    end

    assign t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_w;

    assign o_work.a = t;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;

endmodule
